// File: rtl/cc20_pkg.sv
package cc20_pkg;

	localparam int unsigned DefRounds = 20;
	localparam int unsigned FifoDepth = 2;

	typedef logic [31:0] word_t;

	// "expand 32-byte k"
	localparam word_t [3:0] SIGMA = '{32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865};

	// register indices
	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_NONCEL = 3'd4;
	localparam logic [2:0] REG_NONCEH = 3'd5;
	localparam logic [2:0] REG_CTR    = 3'd6;

	// item held between front and back
	typedef struct packed {
		logic        start;
		logic [3:0]  count;
		logic [63:0] data;
	} item_t;

	// configuration as seen by the back end
	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
		logic [31:0]      init_ctr;
	} cfg_t;

endpackage

// File: rtl/cc20_front.sv
module cc20_front import cc20_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] in_data,
	input  logic [3:0]  in_count,
	input  logic        in_start,
	output logic        head_valid,
	output item_t       head,
	input  logic        pop
);

	localparam int unsigned PtrW = $clog2(FifoDepth);

	item_t            mem_q [FifoDepth];
	logic [PtrW-1:0]  wr_q, rd_q;
	logic [PtrW:0]    fill_q;
	logic             push;
	item_t            entry;

	// clamp the byte count on the way in
	always_comb begin
		entry.data  = in_data;
		entry.start = in_start;
		entry.count = (in_count > 4'd8) ? 4'd8 : in_count;
	end

	assign in_ready   = (fill_q != (PtrW+1)'(FifoDepth));
	assign push       = in_valid && in_ready;
	assign head_valid = (fill_q != '0);
	assign head       = mem_q[rd_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= entry;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(FifoDepth-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(FifoDepth-1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
		end
	end

endmodule

// File: rtl/cc20_core.sv
module cc20_core import cc20_pkg::*; #(
	parameter int unsigned ROUNDS = DefRounds
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  word_t [15:0] init,
	output logic         done,
	output word_t [15:0] ks
);

	localparam int unsigned Halves = 2 * ROUNDS;
	localparam int unsigned HsW    = $clog2(Halves);

	word_t [15:0]   x_q, init_q, nx;
	logic [HsW-1:0] hs_q;
	logic           busy_q, fin_q;

	// one half of a round per cycle, four quarter rounds side by side
	always_comb begin
		logic [1:0] a, b, c, d;
		word_t      va, vb, vc, vd;
		nx = x_q;
		for (int q = 0; q < 4; q++) begin
			a = 2'(q);
			if (hs_q[1]) begin
				b = 2'(q + 1);
				c = 2'(q + 2);
				d = 2'(q + 3);
			end else begin
				b = 2'(q);
				c = 2'(q);
				d = 2'(q);
			end
			va = x_q[{2'd0, a}];
			vb = x_q[{2'd1, b}];
			vc = x_q[{2'd2, c}];
			vd = x_q[{2'd3, d}];
			va = va + vb;
			vd = vd ^ va;
			vd = hs_q[0] ? {vd[23:0], vd[31:24]} : {vd[15:0], vd[31:16]};
			vc = vc + vd;
			vb = vb ^ vc;
			vb = hs_q[0] ? {vb[24:0], vb[31:25]} : {vb[19:0], vb[31:20]};
			nx[{2'd0, a}] = va;
			nx[{2'd1, b}] = vb;
			nx[{2'd2, c}] = vc;
			nx[{2'd3, d}] = vd;
		end
	end

	// feed-forward addition
	always_comb begin
		for (int i = 0; i < 16; i++) begin
			ks[i] = x_q[i] + init_q[i];
		end
	end

	assign done = fin_q;

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= init;
			init_q <= init;
		end else if (busy_q) begin
			x_q <= nx;
		end
	end

	// round sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q   <= '0;
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				hs_q   <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				hs_q <= hs_q + 1'b1;
				if (hs_q == HsW'(Halves - 1)) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/cc20_back.sv
module cc20_back import cc20_pkg::*; #(
	parameter int unsigned ROUNDS = DefRounds
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        head_valid,
	input  item_t       head,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] out_data,
	output logic [3:0]  out_count
);

	logic [31:0]  ctr_q;
	logic [2:0]   wp_q;
	logic         ready_q, started_q, gen_q;
	logic [511:0] ks_q;
	logic         ov_q;
	logic [63:0]  od_q;
	logic [3:0]   oc_q;

	logic         do_start, out_free, emit, gen_go, core_done;
	logic [31:0]  ectr;
	logic [2:0]   ewp;
	logic         eready;
	word_t [15:0] init, core_ks;
	logic [63:0]  xored;

	// message start applies once per head item
	assign do_start = head_valid && head.start && !started_q;
	assign ectr     = do_start ? cfg.init_ctr : ctr_q;
	assign ewp      = do_start ? 3'd0 : wp_q;
	assign eready   = do_start ? 1'b0 : ready_q;
	assign out_free = !ov_q || out_ready;

	// starting state of a block
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init[i]         = SIGMA[i];
			init[4 + 2 * i] = cfg.key[i][31:0];
			init[5 + 2 * i] = cfg.key[i][63:32];
		end
		init[12] = ectr;
		init[13] = cfg.nonce_low[31:0];
		init[14] = cfg.nonce_low[63:32];
		init[15] = cfg.nonce_high;
	end

	// dispatch of the head item
	always_comb begin
		pop    = 1'b0;
		emit   = 1'b0;
		gen_go = 1'b0;
		if (head_valid && !gen_q) begin
			if (head.count == 4'd0) begin
				pop = out_free;
			end else if (!eready) begin
				gen_go = 1'b1;
			end else begin
				pop  = out_free;
				emit = out_free;
			end
		end
	end

	// masked xor with the next slice
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			xored[8*i +: 8] = (4'(i) < head.count) ? (head.data[8*i +: 8] ^ ks_q[8*i +: 8]) : 8'd0;
		end
	end

	cc20_core #(.ROUNDS(ROUNDS)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gen_go),
		.init   (init),
		.done   (core_done),
		.ks     (core_ks)
	);

	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_count = oc_q;

	always_ff @(posedge clk) begin
		if (core_done) begin
			ks_q <= core_ks;
		end else if (emit) begin
			ks_q <= {64'd0, ks_q[511:64]};
		end
		if (pop) begin
			od_q <= emit ? xored : 64'd0;
			oc_q <= head.count;
		end
	end

	// block position and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q     <= '0;
			wp_q      <= '0;
			ready_q   <= 1'b0;
			started_q <= 1'b0;
			gen_q     <= 1'b0;
			ov_q      <= 1'b0;
		end else begin
			if (pop) begin
				started_q <= 1'b0;
			end else if (do_start && !gen_q) begin
				started_q <= 1'b1;
			end
			if (head_valid && !gen_q) begin
				ctr_q   <= ectr;
				wp_q    <= ewp;
				ready_q <= eready;
				if (emit) begin
					wp_q <= ewp + 1'b1;
					if (ewp == 3'd7) begin
						ctr_q   <= ectr + 1'b1;
						ready_q <= 1'b0;
					end
				end
			end
			if (gen_go) begin
				gen_q <= 1'b1;
			end else if (core_done) begin
				gen_q   <= 1'b0;
				ready_q <= 1'b1;
			end
			if (pop) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/chacha20_stream_cipher.sv
// ChaCha20 stream cipher, up to 8 message bytes per transfer.
// Configuration: write key (indices 0-3), nonce (4, 5) and the initial block
// counter (6) over the cfg channel while no message is in flight; cfg_ready is
// always high. Indices beyond 6 are ignored.
// Input: s_tdata carries data_in in bits 63:0 and byte_count in 67:64;
// s_tuser is message_start, which reloads the counter for a new message.
// Output: m_tdata carries data_out in 63:0 and byte_count_out in 67:64.
// An item using a ready keystream block passes through the input queue and
// the output register to m_tdata; the first item of each 64-byte block waits for
// the block, which the single iterative round unit computes in half rounds
// before the feed-forward addition. The sustained rate is set by that round
// unit.
// A two-entry input queue takes items while the round unit works or the
// output register waits; once it holds two items s_tready drops. When m_tready
// is low the result holds in the output register and the queue fills.
// Reset clears configuration, counter and all queues.
module chacha20_stream_cipher import cc20_pkg::*; #(
	parameter int unsigned ROUNDS = DefRounds
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // data_in[63:0], byte_count[67:64], zero pad
	input  logic        s_tuser,  // message_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // data_out[63:0], byte_count_out[67:64], zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	cfg_t        cfg_q;
	logic        head_valid, pop;
	item_t       head;
	logic [63:0] out_data;
	logic [3:0]  out_count;
	logic [3:0]  pad_unused;

	assign cfg_ready  = 1'b1;
	assign pad_unused = s_tdata[71:68];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY0:   cfg_q.key[0]     <= cfg_data;
				REG_KEY1:   cfg_q.key[1]     <= cfg_data;
				REG_KEY2:   cfg_q.key[2]     <= cfg_data;
				REG_KEY3:   cfg_q.key[3]     <= cfg_data;
				REG_NONCEL: cfg_q.nonce_low  <= cfg_data;
				REG_NONCEH: cfg_q.nonce_high <= cfg_data[31:0];
				REG_CTR:    cfg_q.init_ctr   <= cfg_data[31:0];
				default:    cfg_q            <= cfg_q;
			endcase
		end
	end

	cc20_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata[63:0]),
		.in_count   (s_tdata[67:64] | (pad_unused & 4'd0)),
		.in_start   (s_tuser),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	cc20_back #(.ROUNDS(ROUNDS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_data),
		.out_count  (out_count)
	);

	assign m_tdata = {4'd0, out_count, out_data};

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import cc20_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // data_in[63:0], byte_count[67:64], zero pad
	logic        s_tuser;  // message_start
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;  // data_out[63:0], byte_count_out[67:64], zero pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	typedef struct packed {
		logic [3:0]  count;
		logic [63:0] data;
	} cipher_out_t;

	chacha20_stream_cipher i_dut (.*);

	// predictor state and its copy of the configuration
	logic [3:0][63:0] key_q;
	logic [63:0]      nonce_lo_q;
	logic [31:0]      nonce_hi_q;
	logic [31:0]      init_ctr_q;
	logic [31:0]      ks_words [16];
	logic [31:0]      blk_ctr;
	logic [2:0]       slice_pos;
	logic             ks_valid;

	cipher_out_t cipher_q[$];
	int          n_errors;
	int          send_idle_pct;
	int          recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#400ms;
		$display("chacha20_stream_cipher: mismatch");
		$finish;
	end

	function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	task automatic qr(inout logic [31:0] x [16], input int a, input int b,
			input int c, input int d);
		x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 16);
		x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 12);
		x[a] = x[a] + x[b]; x[d] = rotl(x[d] ^ x[a], 8);
		x[c] = x[c] + x[d]; x[b] = rotl(x[b] ^ x[c], 7);
	endtask

	// keystream block for the current counter
	task automatic build_keystream();
		logic [31:0] init [16];
		logic [31:0] x [16];
		init[0] = 32'h61707865; init[1] = 32'h3320646e;
		init[2] = 32'h79622d32; init[3] = 32'h6b206574;
		for (int i = 0; i < 4; i++) begin
			init[4 + 2 * i] = key_q[i][31:0];
			init[5 + 2 * i] = key_q[i][63:32];
		end
		init[12] = blk_ctr;
		init[13] = nonce_lo_q[31:0];
		init[14] = nonce_lo_q[63:32];
		init[15] = nonce_hi_q;
		x = init;
		for (int r = 0; r < DefRounds; r++) begin
			if (r % 2 == 0) begin
				qr(x, 0, 4, 8, 12); qr(x, 1, 5, 9, 13);
				qr(x, 2, 6, 10, 14); qr(x, 3, 7, 11, 15);
			end else begin
				qr(x, 0, 5, 10, 15); qr(x, 1, 6, 11, 12);
				qr(x, 2, 7, 8, 13); qr(x, 3, 4, 9, 14);
			end
		end
		for (int i = 0; i < 16; i++)
			ks_words[i] = x[i] + init[i];
	endtask

	task automatic predict_cipher(input logic [63:0] data, input logic [3:0] cnt,
			input logic start);
		cipher_out_t res;
		logic [63:0] ks;
		logic [63:0] mask;
		int          n;
		if (start) begin
			blk_ctr   = init_ctr_q;
			slice_pos = 3'd0;
			ks_valid  = 1'b0;
		end
		n = (cnt > 8) ? 8 : cnt;
		if (n == 0) begin
			cipher_q.push_back('0);
			return;
		end
		if (!ks_valid) begin
			build_keystream();
			ks_valid = 1'b1;
		end
		ks = {ks_words[2 * slice_pos + 1], ks_words[2 * slice_pos]};
		mask = (n == 8) ? '1 : ((64'd1 << (8 * n)) - 64'd1);
		res.data  = (data ^ ks) & mask;
		res.count = n[3:0];
		cipher_q.push_back(res);
		slice_pos = slice_pos + 3'd1;
		if (slice_pos == 3'd0) begin
			blk_ctr  = blk_ctr + 32'd1;
			ks_valid = 1'b0;
		end
	endtask

	// one input transfer; tvalid stays high until the next item or a drain
	task automatic send_item(input logic [63:0] data, input logic [3:0] cnt,
			input logic start);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'd0, cnt, data};
		s_tuser  <= start;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_cipher(data, cnt, start);
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (cipher_q.size() > 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_KEY0:   key_q[0]   = val;
			REG_KEY1:   key_q[1]   = val;
			REG_KEY2:   key_q[2]   = val;
			REG_KEY3:   key_q[3]   = val;
			REG_NONCEL: nonce_lo_q = val;
			REG_NONCEH: nonce_hi_q = val[31:0];
			REG_CTR:    init_ctr_q = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_config(input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3, input logic [63:0] nl,
			input logic [31:0] nh, input logic [31:0] ctr);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		write_reg(REG_NONCEL, nl);
		write_reg(REG_NONCEH, {32'd0, nh});
		write_reg(REG_CTR, {32'd0, ctr});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// extremes of data and count, count zero and above eight, restarts
	task automatic test_directed();
		send_item('0, 4'd8, 1'b1);
		send_item('1, 4'd8, 1'b0);
		send_item(64'h0123456789abcdef, 4'd1, 1'b0);
		send_item(rand64(), 4'd0, 1'b0);
		send_item(rand64(), 4'd15, 1'b0);
		send_item(rand64(), 4'd9, 1'b0);
		for (int i = 2; i <= 7; i++)
			send_item(rand64(), i[3:0], 1'b0);
		send_item(rand64(), 4'd3, 1'b1);
		send_item(rand64(), 4'd0, 1'b1);
		for (int i = 0; i < 10; i++)
			send_item(rand64(), 4'd8, 1'b0);
		drain();
	endtask

	// counter wrap across a block boundary
	task automatic test_counter_wrap();
		load_config('1, '1, '1, '1, '1, 32'hffffffff, 32'hffffffff);
		for (int i = 0; i < 20; i++)
			send_item(rand64(), 4'd8, i == 0);
		drain();
	endtask

	// random messages: mostly full items, short final item, some noise
	task automatic test_random_messages(input int n_items);
		int sent;
		int len;
		int c;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 40);
			for (int i = 0; i < len; i++) begin
				c = 8;
				if (i == len - 1 && $urandom_range(1)) c = $urandom_range(1, 7);
				if ($urandom_range(99) < 3) c = $urandom_range(15);
				send_item(rand64(), c[3:0], i == 0);
				sent++;
			end
			if ($urandom_range(9) == 0) begin
				// let every result come back before carrying on
				drain();
			end
		end
		drain();
	endtask

	// receiver: random stall, checks each transfer
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (cipher_q.size() == 0) begin
				$display("%0t unexpected result %h", $time, m_tdata);
				n_errors++;
			end else begin
				cipher_out_t exp_r;
				exp_r = cipher_q.pop_front();
				if (m_tdata[63:0] !== exp_r.data)
					$display("%0t data exp %h got %h", $time, exp_r.data, m_tdata[63:0]);
				if (m_tdata[67:64] !== exp_r.count)
					$display("%0t count exp %0d got %0d", $time, exp_r.count,
						m_tdata[67:64]);
				if (m_tdata[63:0] !== exp_r.data || m_tdata[67:64] !== exp_r.count)
					n_errors++;
			end
		end
		m_tready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	initial begin
		n_errors       = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		m_tready  = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY0;
		cfg_data  = '0;
		key_q      = '0;
		nonce_lo_q = '0;
		nonce_hi_q = '0;
		init_ctr_q = '0;
		blk_ctr    = '0;
		slice_pos  = '0;
		ks_valid   = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_counter_wrap();
		load_config(64'h0706050403020100, 64'h0f0e0d0c0b0a0908,
			64'h1716151413121110, 64'h1f1e1d1c1b1a1918,
			64'h4a00000000000000, 32'h0, 32'd1);
		test_random_messages(300);
		send_idle_pct = 85;
		load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, $urandom);
		test_random_messages(250);
		send_idle_pct  = 0;
		recv_stall_pct = 85;
		load_config('0, '0, '0, '0, '0, '0, '0);
		test_random_messages(250);
		send_idle_pct  = 37;
		recv_stall_pct = 37;
		load_config(rand64(), rand64(), rand64(), rand64(), rand64(), $urandom, '1);
		test_random_messages(350);
		recv_stall_pct = 0;

		if (cipher_q.size() != 0) begin
			$display("%0t %0d results missing", $time, cipher_q.size());
			n_errors++;
		end
		if (n_errors == 0)
			$display("chacha20_stream_cipher: match");
		else
			$display("chacha20_stream_cipher: mismatch");
		$finish;
	end

endmodule
